@@ rtl/tbr_pkg.sv @@
// Shared types and constants for the Thumb branch resolve unit.
`default_nettype none
package tbr_pkg;

	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 40;
	localparam int unsigned OFFSET_W   = 25;

	typedef enum logic [1:0] {
		CMD_B_T1 = 2'd0,
		CMD_B_T2 = 2'd1,
		CMD_B_T3 = 2'd2,
		CMD_B_T4 = 2'd3
	} tbr_cmd_t;

	localparam logic [3:0] COND_NEVER = 4'd15;

	typedef struct packed {
		logic [31:0]         pc;
		logic [OFFSET_W-1:0] offset;
		logic                taken;
		logic                svc;
	} tbr_entry_t;

endpackage
`default_nettype wire

@@ rtl/tbr_front.sv @@
// Front end: accepts a request and decodes offset, condition and taken status.
`default_nettype none
module tbr_front
	import tbr_pkg::*;
(
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic [IN_USER_W-1:0] s_axis_tuser,
	output logic                      push,
	input  wire logic                 q_ready,
	output tbr_entry_t                entry
);

	function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] nzcv);
		logic r;
		r = 1'b1;
		case (cond[3:1])
			3'd0:    r = nzcv[2];
			3'd1:    r = nzcv[1];
			3'd2:    r = nzcv[3];
			3'd3:    r = nzcv[0];
			3'd4:    r = nzcv[1] & ~nzcv[2];
			3'd5:    r = (nzcv[3] == nzcv[0]);
			3'd6:    r = (nzcv[3] == nzcv[0]) & ~nzcv[2];
			default: r = 1'b1;
		endcase
		if (cond[0] && (cond != COND_NEVER)) begin
			r = ~r;
		end
		return r;
	endfunction

	logic [15:0] lo;
	logic [15:0] hi;
	logic [3:0]  nzcv;
	logic        in_it;
	logic        last_it;
	logic        s_bit;
	logic        j1;
	logic        j2;
	logic [3:0]  cond_t1;
	logic [3:0]  cond_t3;
	tbr_cmd_t    cmd;

	assign lo      = s_axis_tdata[15:0];
	assign hi      = s_axis_tdata[31:16];
	assign nzcv    = s_axis_tdata[67:64];
	assign in_it   = s_axis_tdata[68];
	assign last_it = s_axis_tdata[69];
	assign s_bit   = hi[10];
	assign j1      = lo[13];
	assign j2      = lo[11];
	assign cond_t1 = lo[11:8];
	assign cond_t3 = hi[9:6];
	assign cmd     = tbr_cmd_t'(s_axis_tuser);

	assign s_axis_tready = q_ready;
	assign push          = s_axis_tvalid & q_ready;

	always_comb begin
		entry.pc     = s_axis_tdata[63:32];
		entry.offset = '0;
		entry.taken  = 1'b0;
		entry.svc    = 1'b0;
		case (cmd)
			CMD_B_T1: begin
				if (cond_t1 == COND_NEVER) begin
					entry.svc = 1'b1;
				end else begin
					entry.offset = {{(OFFSET_W-9){lo[7]}}, lo[7:0], 1'b0};
					entry.taken  = ~in_it & cond_holds(cond_t1, nzcv);
				end
			end
			CMD_B_T2: begin
				entry.offset = {{(OFFSET_W-12){lo[10]}}, lo[10:0], 1'b0};
				entry.taken  = ~in_it & ~last_it;
			end
			CMD_B_T3: begin
				entry.offset = {{(OFFSET_W-21){s_bit}}, s_bit, j2, j1, hi[5:0], lo[10:0], 1'b0};
				entry.taken  = cond_holds(cond_t3, nzcv);
			end
			CMD_B_T4: begin
				entry.offset = {s_bit, ~(j1 ^ s_bit), ~(j2 ^ s_bit), hi[9:0], lo[10:0], 1'b0};
				entry.taken  = 1'b1;
			end
			default: begin
				entry.taken = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/tbr_queue.sv @@
// Small request queue between the decode front end and the target back end.
`default_nettype none
module tbr_queue
	import tbr_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire tbr_entry_t push_entry,
	output logic            ready,
	input  wire logic       pop,
	output logic            valid,
	output tbr_entry_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tbr_entry_t       entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready = (count_q != CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/tbr_back.sv @@
// Back end: forms the branch target and holds the result in the output register.
`default_nettype none
module tbr_back
	import tbr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire tbr_entry_t            head,
	output logic                       pop,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	logic                  out_valid_q;
	logic                  taken_q;
	logic [31:0]           next_pc_q;
	logic                  svc_q;
	logic [31:0]           target;

	assign pop    = q_valid & (~out_valid_q | m_axis_tready);
	assign target = head.pc + {{(32-OFFSET_W){head.offset[OFFSET_W-1]}}, head.offset} + 32'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			taken_q   <= head.taken;
			next_pc_q <= head.taken ? target : head.pc;
			svc_q     <= head.svc;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-34){1'b0}}, svc_q, next_pc_q, taken_q};

endmodule
`default_nettype wire

@@ rtl/thumb_branch_resolve_unit.sv @@
// Top level of the Thumb branch resolve unit.
//
// Channel  Dir  Signals                       Contents
// s_axis   in   tvalid tready tdata[71:0]     branch request
//                     tuser[1:0]              encoding
// m_axis   out  tvalid tready tdata[39:0]     taken, next PC, supervisor call
//
// One request is accepted per cycle while the queue has room; its result passes
// through the queue and then the output register before it is presented on m_axis.
// With m_axis_tready held high the sustained rate is one request per cycle,
// because the output register reloads from the queue in the same cycle that its
// result is taken.
// Reset empties the queue and the output register; nothing else is cleared.
// A stalled output fills the queue, after which s_axis_tready drops.
`default_nettype none
module thumb_branch_resolve_unit
	import tbr_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// second_halfword, first_halfword, current_pc, nzcv_flags,
	// inside_it_block, last_of_it_block, zero padding
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// command
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// taken, next_pc, supervisor_call, zero padding
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	logic       push;
	logic       q_ready;
	logic       q_valid;
	logic       pop;
	tbr_entry_t push_entry;
	tbr_entry_t head;

	tbr_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.push          (push),
		.q_ready       (q_ready),
		.entry         (push_entry)
	);

	tbr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.ready      (q_ready),
		.pop        (pop),
		.valid      (q_valid),
		.head       (head)
	);

	tbr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
`default_nettype wire

@@ rtl/tbr_checker.sv @@
// Port-level checker for the Thumb branch resolve unit and its bind.
`default_nettype none
module tbr_port_checks
	import tbr_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input wire logic [IN_USER_W-1:0]  s_axis_tuser,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic [IN_DATA_W+IN_USER_W:0] in_probe;

	assign in_probe = {s_axis_tvalid, s_axis_tdata, s_axis_tuser};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_svc_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[33] |-> !m_axis_tdata[0])
		else $error("supervisor call reported as taken");

	a_full_means_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !$isunknown(in_probe) |=> ##1 m_axis_tvalid)
		else $error("accepted request produced no result");

endmodule

bind thumb_branch_resolve_unit tbr_port_checks u_tbr_checker (.*);
`default_nettype wire

@@ dv/tbr_checker.sv @@
// Checker for the Thumb branch resolve unit: predicts each branch outcome and compares results.
`timescale 1ns / 1ps
module tbr_checker
	import tbr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	input  wire logic                  s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
	input  wire logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                         failures,
	output int                         pending,
	output int                         checked
);

	localparam logic [3:0] COND_EQ = 4'd0;
	localparam logic [3:0] COND_CS = 4'd2;
	localparam logic [3:0] COND_MI = 4'd4;
	localparam logic [3:0] COND_VS = 4'd6;
	localparam logic [3:0] COND_HI = 4'd8;
	localparam logic [3:0] COND_GE = 4'd10;
	localparam logic [3:0] COND_GT = 4'd12;

	typedef struct packed {
		logic        taken;
		logic [31:0] next_pc;
		logic        svc;
	} branch_outcome_t;

	branch_outcome_t outcome_q[$];

	function automatic logic cond_passes(input logic [3:0] cond, input logic [3:0] nzcv);
		logic n, z, c, v, r;
		n = nzcv[3];
		z = nzcv[2];
		c = nzcv[1];
		v = nzcv[0];
		case ({cond[3:1], 1'b0})
			COND_EQ: r = z;
			COND_CS: r = c;
			COND_MI: r = n;
			COND_VS: r = v;
			COND_HI: r = c && !z;
			COND_GE: r = (n == v);
			COND_GT: r = (n == v) && !z;
			default: r = 1'b1;
		endcase
		// Odd codes are the negation of their pair, except the never code which acts as always.
		if (cond[0] && cond != COND_NEVER)
			r = !r;
		return r;
	endfunction

	function automatic branch_outcome_t resolve_branch(input tbr_cmd_t cmd,
			input logic [15:0] lo, input logic [15:0] hi, input logic [31:0] pc,
			input logic [3:0] nzcv, input logic in_it, input logic last_it);
		branch_outcome_t res;
		logic [31:0] offset;
		logic s, j1, j2;
		s = hi[10];
		j1 = lo[13];
		j2 = lo[11];
		offset = '0;
		res.taken = 1'b0;
		res.svc = 1'b0;
		case (cmd)
			CMD_B_T1: begin
				if (lo[11:8] == COND_NEVER) begin
					res.svc = 1'b1;
				end else begin
					offset = {{23{lo[7]}}, lo[7:0], 1'b0};
					res.taken = !in_it && cond_passes(lo[11:8], nzcv);
				end
			end
			CMD_B_T2: begin
				offset = {{20{lo[10]}}, lo[10:0], 1'b0};
				res.taken = !in_it && !last_it;
			end
			CMD_B_T3: begin
				offset = {{11{s}}, s, j2, j1, hi[5:0], lo[10:0], 1'b0};
				res.taken = cond_passes(hi[9:6], nzcv);
			end
			default: begin
				offset = {{7{s}}, s, ~(j1 ^ s), ~(j2 ^ s), hi[9:0], lo[10:0], 1'b0};
				res.taken = 1'b1;
			end
		endcase
		res.next_pc = res.taken ? pc + offset + 32'd2 : pc;
		return res;
	endfunction

	initial begin
		failures = 0;
		pending = 0;
		checked = 0;
	end

	always @(posedge clk) begin
		branch_outcome_t want, got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.taken = m_axis_tdata[0];
				got.next_pc = m_axis_tdata[32:1];
				got.svc = m_axis_tdata[33];
				checked++;
				if (outcome_q.size() == 0) begin
					if (failures < 10)
						$display("%0t: unexpected result taken %0b next_pc %08h svc %0b",
							$realtime, got.taken, got.next_pc, got.svc);
					failures++;
				end else begin
					want = outcome_q.pop_front();
					if (got !== want) begin
						if (failures < 10)
							$display("%0t: mismatch expected taken %0b next_pc %08h svc %0b, got taken %0b next_pc %08h svc %0b",
								$realtime, want.taken, want.next_pc, want.svc,
								got.taken, got.next_pc, got.svc);
						failures++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				outcome_q.push_back(resolve_branch(tbr_cmd_t'(s_axis_tuser),
					s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[63:32],
					s_axis_tdata[67:64], s_axis_tdata[68], s_axis_tdata[69]));
		end
		pending = outcome_q.size();
	end

endmodule

@@ dv/tb.sv @@
// Testbench top for the Thumb branch resolve unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
	import tbr_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// second_halfword, first_halfword, current_pc, nzcv_flags,
	// inside_it_block, last_of_it_block, zero padding
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	// command
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// taken, next_pc, supervisor_call, zero padding
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic quiet;
	int   failures;
	int   pending;
	int   checked;
	int   sent_per_cmd[4];

	thumb_branch_resolve_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	tbr_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.failures      (failures),
		.pending       (pending),
		.checked       (checked)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic send_branch(input tbr_cmd_t cmd, input logic [15:0] lo,
			input logic [15:0] hi, input logic [31:0] pc, input logic [3:0] nzcv,
			input logic in_it, input logic last_it);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = cmd;
		s_axis_tdata = {2'b00, last_it, in_it, nzcv, pc, hi, lo};
		sent_per_cmd[cmd]++;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int stall_len;
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_len = $urandom_range(1, 16);
				m_axis_tready = 1'b0;
				repeat (stall_len) @(negedge clk);
				m_axis_tready = 1'b1;
			end
		end
	end

	initial begin
		logic [15:0] r_lo, r_hi;
		logic [31:0] r_pc;
		int n;
		quiet = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_branch(CMD_B_T1, 16'hDF12, 16'h0000, 32'h0000_1000, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T1, 16'hDE7F, 16'h0000, 32'hFFFF_FFF0, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T1, 16'hDE80, 16'h1234, 32'h0000_2000, 4'hF, 1'b1, 1'b0);
		send_branch(CMD_B_T1, 16'hD080, 16'h0000, 32'h0000_0000, 4'h4, 1'b0, 1'b0);
		send_branch(CMD_B_T1, 16'hD1FF, 16'h0000, 32'h0000_0040, 4'h4, 1'b0, 1'b0);
		send_branch(CMD_B_T1, 16'h0000, 16'h0000, 32'h0000_0000, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 1'b1, 1'b1);
		send_branch(CMD_B_T2, 16'hE3FF, 16'h0000, 32'h0000_0100, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T2, 16'hE400, 16'h0000, 32'h0000_0000, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T2, 16'hE123, 16'h0000, 32'h0000_3000, 4'h0, 1'b1, 1'b0);
		send_branch(CMD_B_T2, 16'hE123, 16'h0000, 32'h0000_3000, 4'h0, 1'b0, 1'b1);
		send_branch(CMD_B_T2, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 1'b0, 1'b0);
		send_branch(CMD_B_T3, 16'h8000, 16'hF3C0, 32'h0800_0000, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T3, 16'hAFFF, 16'hF780, 32'h0800_0000, 4'h0, 1'b1, 1'b1);
		send_branch(CMD_B_T3, 16'h8001, 16'hF000, 32'h0000_0010, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T3, 16'hFFFF, 16'hFFFF, 32'h0000_0000, 4'hF, 1'b0, 1'b0);
		send_branch(CMD_B_T3, 16'h0000, 16'h03FF, 32'hFFFF_FFFE, 4'h5, 1'b0, 1'b0);
		send_branch(CMD_B_T4, 16'h9000, 16'hF000, 32'h0000_0000, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T4, 16'hB800, 16'hF400, 32'h0001_0000, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T4, 16'hFFFF, 16'hF7FF, 32'hFFFF_FFFF, 4'h0, 1'b0, 1'b0);
		send_branch(CMD_B_T4, 16'h0000, 16'h0000, 32'h0000_0000, 4'hF, 1'b1, 1'b1);
		send_branch(CMD_B_T4, 16'hD7FF, 16'hF3FF, 32'h7FFF_FFFF, 4'h0, 1'b0, 1'b0);
		drain_results();

		for (n = 0; n < 450; n++) begin
			if (n == 225)
				drain_results();
			if (n == 360)
				quiet = 1'b1;
			r_lo = 16'($urandom());
			r_hi = 16'($urandom());
			case ($urandom_range(0, 3))
				0: r_pc = $urandom_range(0, 255);
				1: r_pc = 32'hFFFF_FF00 | $urandom_range(0, 255);
				default: r_pc = $urandom();
			endcase
			send_branch(tbr_cmd_t'($urandom_range(0, 3)), r_lo, r_hi, r_pc,
				4'($urandom_range(0, 15)), $urandom_range(0, 3) == 0,
				$urandom_range(0, 3) == 0);
		end

		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent T1 %0d, T2 %0d, T3 %0d, T4 %0d branch requests; %0d results checked.",
			sent_per_cmd[0], sent_per_cmd[1], sent_per_cmd[2], sent_per_cmd[3], checked);
		if (failures == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ thumb_branch_resolve_unit.f @@
rtl/tbr_pkg.sv
rtl/tbr_front.sv
rtl/tbr_queue.sv
rtl/tbr_back.sv
rtl/thumb_branch_resolve_unit.sv
rtl/tbr_checker.sv
dv/tbr_checker.sv
dv/tb.sv
